>>> hw/rtl/rbhw_pkg.sv
// Package for the archive block header walker: word types, result codes,
// block layout offsets. No dependencies.
`default_nettype none

package rbhw_pkg;

    // Width of the byte offset inside one block
    localparam int OFF_W = 33;
    // Offset plus one, and header size plus packed size, need one bit more
    localparam int SUM_W = OFF_W + 1;

    localparam logic [2:0]       MARKER_LEN      = 3'd7;
    localparam logic [7:0]       FILE_BLOCK_TYPE = 8'h74;
    localparam logic [15:0]      BASE_HDR_LEN    = 16'd7;
    localparam logic [SUM_W-1:0] NAME_START      = SUM_W'(32);

    // Field offsets inside a block
    localparam logic [OFF_W-1:0] OFF_TYPE   = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_HDR_LO = OFF_W'(5);
    localparam logic [OFF_W-1:0] OFF_HDR_HI = OFF_W'(6);
    localparam logic [OFF_W-1:0] OFF_PK_B0  = OFF_W'(7);
    localparam logic [OFF_W-1:0] OFF_PK_B1  = OFF_W'(8);
    localparam logic [OFF_W-1:0] OFF_PK_B2  = OFF_W'(9);
    localparam logic [OFF_W-1:0] OFF_PK_B3  = OFF_W'(10);
    localparam logic [OFF_W-1:0] OFF_NC_LO  = OFF_W'(26);
    localparam logic [OFF_W-1:0] OFF_NC_HI  = OFF_W'(27);
    localparam logic [OFF_W-1:0] OFF_RECORD = OFF_W'(31);

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_archive;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_char;
        logic [31:0] packed_size;
        logic [15:0] name_length;
        logic        last_name_char;
    } t_out_word;

endpackage

`default_nettype wire

>>> hw/rtl/rbhw_core.sv
// Per-byte parser state and next-state logic of the block header walker.
// Depends on rbhw_pkg.
`default_nettype none

module rbhw_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire rbhw_pkg::t_in_word  i_word,
    output logic                   o_res_valid,
    output rbhw_pkg::t_out_word    o_res
);
    import rbhw_pkg::*;

    logic [2:0]       r_marker, n_marker;
    logic [OFF_W-1:0] r_offset, n_offset;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_hdr, n_hdr;
    logic [31:0]      r_pk, n_pk;
    logic [15:0]      r_nc, n_nc;
    logic             r_bad, n_bad;

    logic [7:0]       type_v;
    logic [15:0]      hdr_v;
    logic [31:0]      pk_v;
    logic [15:0]      nc_v;
    logic [SUM_W-1:0] off_ext, off_inc, total, name_end, hdr_ext;
    logic             is_file, ends;
    logic [7:0]       b;

    assign b = i_word.data_byte;

    // Field capture at fixed offsets
    always_comb begin
        type_v = r_type;
        hdr_v  = r_hdr;
        pk_v   = r_pk;
        nc_v   = r_nc;
        case (r_offset)
            OFF_TYPE:   type_v       = b;
            OFF_HDR_LO: hdr_v[7:0]   = b;
            OFF_HDR_HI: hdr_v[15:8]  = b;
            OFF_PK_B0:  pk_v[7:0]    = b;
            OFF_PK_B1:  pk_v[15:8]   = b;
            OFF_PK_B2:  pk_v[23:16]  = b;
            OFF_PK_B3:  pk_v[31:24]  = b;
            OFF_NC_LO:  nc_v[7:0]    = b;
            OFF_NC_HI:  nc_v[15:8]   = b;
            default: ;
        endcase
    end

    assign is_file  = (type_v == FILE_BLOCK_TYPE);
    assign off_ext  = {1'b0, r_offset};
    assign off_inc  = off_ext + SUM_W'(1);
    assign hdr_ext  = SUM_W'(hdr_v);
    assign total    = SUM_W'(hdr_v) + SUM_W'(pk_v);
    assign name_end = NAME_START + SUM_W'(nc_v);

    // File block length is only known once the packed size is complete
    always_comb begin
        ends = 1'b0;
        if (r_offset >= OFF_HDR_HI) begin
            if (is_file) begin
                ends = (r_offset >= OFF_PK_B3) && (off_inc >= total);
            end else begin
                ends = (off_inc >= hdr_ext);
            end
        end
    end

    always_comb begin
        n_marker    = r_marker;
        n_offset    = r_offset;
        n_type      = r_type;
        n_hdr       = r_hdr;
        n_pk        = r_pk;
        n_nc        = r_nc;
        n_bad       = r_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_ENTRY;

        if (r_marker < MARKER_LEN) begin
            n_marker = r_marker + 3'd1;
        end else if (!r_bad) begin
            n_type = type_v;
            n_hdr  = hdr_v;
            n_pk   = pk_v;
            n_nc   = nc_v;
            if (r_offset == OFF_HDR_HI && hdr_v < BASE_HDR_LEN) begin
                n_bad       = 1'b1;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_BAD;
            end else begin
                if (is_file && r_offset == OFF_RECORD) begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_ENTRY;
                    o_res.packed_size = pk_v;
                    o_res.name_length = nc_v;
                end else if (is_file && off_ext >= NAME_START && off_ext < hdr_ext
                             && off_ext < name_end) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_NAME;
                    o_res.name_char      = b;
                    o_res.last_name_char = (off_inc == name_end) || (off_inc == hdr_ext);
                end
                if (ends) begin
                    n_offset = '0;
                    n_type   = '0;
                    n_hdr    = '0;
                    n_pk     = '0;
                    n_nc     = '0;
                end else begin
                    n_offset = off_inc[OFF_W-1:0];
                end
            end
        end

        // End of archive returns everything to marker skipping
        if (i_word.end_of_archive) begin
            n_marker = '0;
            n_bad    = 1'b0;
            n_offset = '0;
            n_type   = '0;
            n_hdr    = '0;
            n_pk     = '0;
            n_nc     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
            r_offset <= '0;
            r_type   <= '0;
            r_hdr    <= '0;
            r_pk     <= '0;
            r_nc     <= '0;
            r_bad    <= 1'b0;
        end else if (i_advance) begin
            r_marker <= n_marker;
            r_offset <= n_offset;
            r_type   <= n_type;
            r_hdr    <= n_hdr;
            r_pk     <= n_pk;
            r_nc     <= n_nc;
            r_bad    <= n_bad;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rar_block_header_walker.sv
// Top level of the archive block header walker: input register, parser core,
// result register. Depends on rbhw_pkg and rbhw_core.
//
// Walks an archive in the RAR 1.5..4.x block layout, one byte word per cycle
// while the result side does not stall. Each accepted byte is held in an input
// register and parsed against the block offset counter once the result register
// is free; any resulting word (file-entry record, name character or
// malformed-header flag) lands in the result register. Sustained rate is one byte
// per cycle while the result side does not stall; it is set by the per-byte offset
// counter update together with the 34-bit block-end compare. A stalled result
// register holds the input side only once the input register is also full. Bytes
// that cause no result just update the parser state.
`default_nettype none

module rar_block_header_walker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rbhw_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output rbhw_pkg::t_out_word      o_out_word
);
    import rbhw_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      w_out_free, w_advance, w_res_valid;
    t_out_word w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    rbhw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_word      (r_in_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res_valid) |=> (o_out_valid && o_out_word == $past(w_res)))
        else $error("parsed result not registered");

    a_name_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind != KIND_NAME)
        |-> (!o_out_word.last_name_char && o_out_word.name_char == 8'd0))
        else $error("name fields set on a non-name word");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a held word");

endmodule

`default_nettype wire
